// ----- rtl/core/xcfp_pkg.sv -----
// Shared constants and controller/datapath interface types for the frame parser.
`timescale 1ns / 1ps

package xcfp_pkg;

  localparam int PAYLOAD_CAPACITY_DEF = 32;
  localparam int OUT_LEN_W            = 6;

  localparam logic [7:0] CH_U     = 8'h55;  // 'U'
  localparam logic [7:0] CH_N     = 8'h4E;  // 'N'
  localparam logic [7:0] CH_E     = 8'h45;  // 'E'
  localparam logic [7:0] CH_R     = 8'h52;  // 'R'
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] HDR_LEN_OVERHEAD = 8'd2;

  typedef struct packed {
    logic xor_init;    // start checksum with current byte
    logic xor_acc;     // fold current byte into checksum
    logic load_len;
    logic load_cmd;    // also clears payload count
    logic store_byte;
    logic start_run;
    logic do_read;
    logic load_out;
  } xcfp_cmd_t;

  typedef struct packed {
    logic match_u;
    logic match_n;
    logic match_e;
    logic match_r;
    logic match_col;
    logic len_gt2;
    logic payload_done;
    logic csum_ok;
    logic stored_zero;
    logic run_last;
    logic out_free;
  } xcfp_status_t;

endpackage

// ----- rtl/core/xor_checksum_frame_parser_top.sv -----
// Parser for header-framed bytes: one received byte a request in, frame results out.
// A received byte is taken on each request while the input is not stalled; the
// header, length, command, payload and checksum bytes each take one request.
// When the checksum byte matches, the input is stalled while the frame's
// results are sent: each stored payload byte is read from the payload store
// and then loaded into the output register, a load that waits while the output
// is stalled; an empty frame gives one result. The last result may wait in the
// output register while the next frame's bytes arrive.
// Payload bytes past the store capacity enter the checksum but are dropped,
// and the results then report the saturated length with truncated set.
`timescale 1ns / 1ps

module xor_checksum_frame_parser_top import xcfp_pkg::*; #(
  parameter int PAYLOAD_CAPACITY = PAYLOAD_CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           command,
  output logic [7:0]           payload_byte,
  output logic                 has_payload,
  output logic [OUT_LEN_W-1:0] stored_length,
  output logic                 truncated,
  output logic                 last
);

  xcfp_cmd_t    cmd;
  xcfp_status_t status;
  logic         busy;
  logic         in_accept;

  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;

  xcfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  xcfp_datapath #(
    .PAYLOAD_CAPACITY (PAYLOAD_CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .rx_byte       (rx_byte),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .command       (command),
    .payload_byte  (payload_byte),
    .has_payload   (has_payload),
    .stored_length (stored_length),
    .truncated     (truncated),
    .last          (last)
  );

endmodule

// ----- rtl/core/xcfp_datapath.sv -----
// Datapath: checksum, length/command registers, payload store and output register.
`timescale 1ns / 1ps

module xcfp_datapath import xcfp_pkg::*; #(
  parameter int PAYLOAD_CAPACITY = PAYLOAD_CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        rx_byte,
  input  xcfp_cmd_t         cmd,
  output xcfp_status_t      status,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        command,
  output logic [7:0]        payload_byte,
  output logic              has_payload,
  output logic [OUT_LEN_W-1:0] stored_length,
  output logic              truncated,
  output logic              last
);

  localparam int ADDR_W   = (PAYLOAD_CAPACITY > 1) ? $clog2(PAYLOAD_CAPACITY) : 1;
  localparam int STORED_W = $clog2(PAYLOAD_CAPACITY + 1);
  localparam logic [7:0] CAP8 = 8'(PAYLOAD_CAPACITY);

  logic [7:0]          running_xor;
  logic [7:0]          declared_length;
  logic [7:0]          frame_command;
  logic [7:0]          byte_count;
  logic [ADDR_W-1:0]   rd_idx;
  logic [7:0]          rd_data;
  logic [7:0]          mem [PAYLOAD_CAPACITY];

  logic                wr_en;
  logic                trunc;
  logic [STORED_W-1:0] stored;
  logic [STORED_W+OUT_LEN_W-1:0] stored_ext;
  logic [8:0]          count_inc;
  logic [8:0]          len_less2;
  logic                last_next;

  assign trunc      = byte_count > CAP8;
  assign stored     = trunc ? STORED_W'(PAYLOAD_CAPACITY) : STORED_W'(byte_count);
  assign stored_ext = {{OUT_LEN_W{1'b0}}, stored};
  assign wr_en      = cmd.store_byte && (byte_count < CAP8);
  assign count_inc  = {1'b0, byte_count} + 9'd1;
  assign len_less2  = {1'b0, declared_length} - {1'b0, HDR_LEN_OVERHEAD};
  assign last_next  = (stored == '0) || ((STORED_W'(rd_idx) + STORED_W'(1)) == stored);

  assign status.match_u      = rx_byte == CH_U;
  assign status.match_n      = rx_byte == CH_N;
  assign status.match_e      = rx_byte == CH_E;
  assign status.match_r      = rx_byte == CH_R;
  assign status.match_col    = rx_byte == CH_COLON;
  assign status.len_gt2      = declared_length > HDR_LEN_OVERHEAD;
  assign status.payload_done = count_inc >= len_less2;
  assign status.csum_ok      = rx_byte == running_xor;
  assign status.stored_zero  = stored == '0;
  assign status.run_last     = last_next;
  assign status.out_free     = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_xor     <= '0;
      declared_length <= '0;
      frame_command   <= '0;
      byte_count      <= '0;
      rd_idx          <= '0;
    end else begin
      if (cmd.xor_init) running_xor <= rx_byte;
      else if (cmd.xor_acc) running_xor <= running_xor ^ rx_byte;
      if (cmd.load_len) declared_length <= rx_byte;
      if (cmd.load_cmd) begin
        frame_command <= rx_byte;
        byte_count    <= '0;
      end else if (cmd.store_byte) begin
        byte_count <= count_inc[7:0];
      end
      if (cmd.start_run) rd_idx <= '0;
      else if (cmd.load_out) rd_idx <= rd_idx + ADDR_W'(1);
    end
  end

  // Payload store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[byte_count[ADDR_W-1:0]] <= rx_byte;
    if (cmd.do_read) rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      command       <= frame_command;
      payload_byte  <= status.stored_zero ? 8'd0 : rd_data;
      has_payload   <= !status.stored_zero;
      stored_length <= stored_ext[OUT_LEN_W-1:0];
      truncated     <= trunc;
      last          <= last_next;
    end
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("output register overwritten while stalled");

  a_no_read_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(cmd.do_read && cmd.store_byte))
    else $error("store read and write in the same cycle");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_payload) |-> last)
    else $error("empty frame result not marked last");

endmodule

// ----- rtl/core/xcfp_ctrl.sv -----
// Controller: header/payload/checksum sequencing and result run control.
`timescale 1ns / 1ps

module xcfp_ctrl import xcfp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_accept,
  input  xcfp_status_t status,
  output xcfp_cmd_t    cmd,
  output logic         busy
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_GOT_U, ST_GOT_N, ST_GOT_E, ST_GOT_R, ST_GOT_LEN,
    ST_GOT_COL, ST_PAYLOAD, ST_CHECK, ST_READ, ST_LOAD
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_accept && status.match_u) begin
        cmd.xor_init = 1'b1;
        state_next   = ST_GOT_U;
      end
      ST_GOT_U: if (in_accept) begin
        cmd.xor_acc = status.match_n;
        state_next  = status.match_n ? ST_GOT_N : ST_IDLE;
      end
      ST_GOT_N: if (in_accept) begin
        cmd.xor_acc = status.match_e;
        state_next  = status.match_e ? ST_GOT_E : ST_IDLE;
      end
      ST_GOT_E: if (in_accept) begin
        cmd.xor_acc = status.match_r;
        state_next  = status.match_r ? ST_GOT_R : ST_IDLE;
      end
      ST_GOT_R: if (in_accept) begin
        cmd.xor_acc  = 1'b1;
        cmd.load_len = 1'b1;
        state_next   = ST_GOT_LEN;
      end
      ST_GOT_LEN: if (in_accept) begin
        cmd.xor_acc = status.match_col;
        state_next  = status.match_col ? ST_GOT_COL : ST_IDLE;
      end
      ST_GOT_COL: if (in_accept) begin
        cmd.xor_acc  = 1'b1;
        cmd.load_cmd = 1'b1;
        state_next   = status.len_gt2 ? ST_PAYLOAD : ST_CHECK;
      end
      ST_PAYLOAD: if (in_accept) begin
        cmd.xor_acc    = 1'b1;
        cmd.store_byte = 1'b1;
        if (status.payload_done) state_next = ST_CHECK;
      end
      ST_CHECK: if (in_accept) begin
        cmd.start_run = status.csum_ok;
        if (!status.csum_ok) state_next = ST_IDLE;
        else if (status.stored_zero) state_next = ST_LOAD;
        else state_next = ST_READ;
      end
      ST_READ: begin
        cmd.do_read = 1'b1;
        state_next  = ST_LOAD;
      end
      ST_LOAD: if (status.out_free) begin
        cmd.load_out = 1'b1;
        state_next   = status.run_last ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next == ST_READ) || (state_next == ST_LOAD);
    end
  end

  a_busy_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_LOAD) |-> busy)
    else $error("input not stalled during result run");

  a_no_accept_in_run: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_accept)
    else $error("request accepted during result run");

  a_read_feeds_load: assert property (@(posedge clk) disable iff (rst)
    cmd.do_read |=> (state == ST_LOAD))
    else $error("store read not followed by output load");

endmodule

// ----- tb/xor_checksum_frame_parser_top_tb.sv -----
// Self-checking testbench for the XOR checksum frame parser, with a random byte stream.
`timescale 1ns / 1ps

module xor_checksum_frame_parser_top_tb;
  import xcfp_pkg::*;

  localparam int CAPACITY   = PAYLOAD_CAPACITY_DEF;
  localparam int RAND_BYTES = 470;

  typedef enum logic [3:0] {
    ST_IDLE, ST_U, ST_N, ST_E, ST_R, ST_LEN, ST_COLON, ST_PAYLOAD, ST_CHECK
  } rx_phase_t;

  typedef enum int {CLEAN, BAD_CSUM, HIT_BYTE} frame_fault_t;

  typedef struct packed {
    logic [7:0]           command;
    logic [7:0]           payload_byte;
    logic                 has_payload;
    logic [OUT_LEN_W-1:0] stored_length;
    logic                 truncated;
    logic                 last;
  } frame_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           command;
  logic [7:0]           payload_byte;
  logic                 has_payload;
  logic [OUT_LEN_W-1:0] stored_length;
  logic                 truncated;
  logic                 last;

  xor_checksum_frame_parser_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .command      (command),
    .payload_byte (payload_byte),
    .has_payload  (has_payload),
    .stored_length(stored_length),
    .truncated    (truncated),
    .last         (last)
  );

  always #1 clk = ~clk;

  // Byte stream to send and results still owed by the block
  logic [7:0]    pending_bytes[$];
  frame_result_t frames_due[$];

  // Parser shadow state
  rx_phase_t  rx_phase = ST_IDLE;
  logic [7:0] rx_len = 8'h00;
  logic [7:0] rx_cmd = 8'h00;
  logic [7:0] payload_mem[CAPACITY];
  int         payload_count = 0;
  logic [7:0] csum = 8'h00;

  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;
  logic [15:0] cyc_count = '0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;

  wire calm = (cyc_count[9:8] == 2'b01);

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the shadow parser by one accepted byte; queue any frame results
  task automatic absorb_rx_byte(input logic [7:0] b);
    int            stored;
    logic          trunc;
    frame_result_t r;
    case (rx_phase)
      ST_IDLE: begin
        if (b == CH_U) begin
          csum = b;
          rx_phase = ST_U;
        end
      end
      ST_U: begin
        if (b == CH_N) begin
          csum ^= b;
          rx_phase = ST_N;
        end else rx_phase = ST_IDLE;
      end
      ST_N: begin
        if (b == CH_E) begin
          csum ^= b;
          rx_phase = ST_E;
        end else rx_phase = ST_IDLE;
      end
      ST_E: begin
        if (b == CH_R) begin
          csum ^= b;
          rx_phase = ST_R;
        end else rx_phase = ST_IDLE;
      end
      ST_R: begin
        rx_len = b;
        csum ^= b;
        rx_phase = ST_LEN;
      end
      ST_LEN: begin
        if (b == CH_COLON) begin
          csum ^= b;
          rx_phase = ST_COLON;
        end else rx_phase = ST_IDLE;
      end
      ST_COLON: begin
        rx_cmd = b;
        csum ^= b;
        payload_count = 0;
        rx_phase = (rx_len > HDR_LEN_OVERHEAD) ? ST_PAYLOAD : ST_CHECK;
      end
      ST_PAYLOAD: begin
        if (payload_count < CAPACITY) payload_mem[payload_count] = b;
        csum ^= b;
        payload_count++;
        if (payload_count >= int'(rx_len) - int'(HDR_LEN_OVERHEAD)) rx_phase = ST_CHECK;
      end
      ST_CHECK: begin
        if (b == csum) begin
          stored = (payload_count > CAPACITY) ? CAPACITY : payload_count;
          trunc  = (payload_count > CAPACITY);
          if (stored == 0) begin
            r = '{rx_cmd, 8'h00, 1'b0, '0, trunc, 1'b1};
            frames_due.push_back(r);
          end else begin
            for (int k = 0; k < stored; k++) begin
              r = '{rx_cmd, payload_mem[k], 1'b1, OUT_LEN_W'(stored), trunc,
                    (k == stored - 1)};
              frames_due.push_back(r);
            end
          end
        end
        rx_phase = ST_IDLE;
      end
      default: rx_phase = ST_IDLE;
    endcase
  endtask

  // Sender: valid stays up while stalled; next request or gap once the slot frees
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) absorb_rx_byte(rx_byte);
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (pending_bytes.size() != 0) begin
          rx_byte  <= pending_bytes.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap(calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted result against the oldest one owed
  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (frames_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result cmd=%02h pay=%02h hp=%0d len=%0d tr=%0d last=%0d",
                     $time, command, payload_byte, has_payload, stored_length, truncated,
                     last);
        end else begin
          want = frames_due.pop_front();
          if (command !== want.command || payload_byte !== want.payload_byte ||
              has_payload !== want.has_payload || stored_length !== want.stored_length ||
              truncated !== want.truncated || last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch exp cmd=%02h pay=%02h hp=%0d len=%0d tr=%0d last=%0d",
                        " got cmd=%02h pay=%02h hp=%0d len=%0d tr=%0d last=%0d"},
                       $time, want.command, want.payload_byte, want.has_payload,
                       want.stored_length, want.truncated, want.last, command,
                       payload_byte, has_payload, stored_length, truncated, last);
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap(calm);
      end
    end
  end

  // One long receiver hold-off while the sender keeps going
  always @(posedge clk) begin
    cyc_count <= cyc_count + 1'b1;
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && results_seen >= 20) begin
      hold_left <= 400;
      hold_used <= 1'b1;
    end
  end

  task automatic queue_frame(input logic [7:0] len, input logic [7:0] cmd,
                             input frame_fault_t fault, input bit rand_fill,
                             input logic [7:0] fill);
    logic [7:0] bytes_q[$];
    logic [7:0] sum;
    int         idx;
    bytes_q = '{CH_U, CH_N, CH_E, CH_R, len, CH_COLON, cmd};
    if (len > HDR_LEN_OVERHEAD)
      repeat (int'(len) - int'(HDR_LEN_OVERHEAD))
        bytes_q.push_back(rand_fill ? 8'($urandom) : fill);
    sum = 8'h00;
    foreach (bytes_q[i]) sum ^= bytes_q[i];
    bytes_q.push_back(fault == BAD_CSUM ? sum ^ 8'($urandom_range(1, 255)) : sum);
    if (fault == HIT_BYTE) begin
      idx = $urandom_range(0, bytes_q.size() - 1);
      bytes_q[idx] ^= 8'($urandom_range(1, 255));
    end
    foreach (bytes_q[i]) pending_bytes.push_back(bytes_q[i]);
  endtask

  function automatic logic [7:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'($urandom_range(0, 2));
    if (r < 80) return 8'($urandom_range(3, 12));
    if (r < 92) return 8'($urandom_range(13, 34));
    return 8'($urandom_range(35, 50));
  endfunction

  // Stimulus and end of run
  initial begin
    int unsigned pick;
    bit          big_done;

    // Directed: empty frame with command 00, one-byte frame with command and payload FF, bad checksum
    queue_frame(8'd0, 8'h00, CLEAN, 1'b0, 8'h00);
    queue_frame(8'd3, 8'hFF, CLEAN, 1'b0, 8'hFF);
    queue_frame(8'd2, 8'hA5, BAD_CSUM, 1'b0, 8'h00);

    big_done = 1'b0;
    while (pending_bytes.size() < RAND_BYTES) begin
      pick = $urandom_range(0, 99);
      if (!big_done && pending_bytes.size() > 200) begin
        // longest declared length, far past the store
        queue_frame(8'd255, 8'($urandom), CLEAN, 1'b1, 8'h00);
        big_done = 1'b1;
      end else if (pick < 70) begin
        queue_frame(pick_len(), 8'($urandom), CLEAN, 1'b1, 8'h00);
      end else if (pick < 82) begin
        queue_frame(pick_len(), 8'($urandom), pick[0] ? BAD_CSUM : HIT_BYTE, 1'b1, 8'h00);
      end else if (pick < 91) begin
        repeat ($urandom_range(1, 5))
          pending_bytes.push_back($urandom_range(0, 3) == 0 ? CH_U : 8'($urandom));
      end else begin
        // broken header; a doubled 'U' must not restart it
        pending_bytes.push_back(CH_U);
        if (pick[0]) pending_bytes.push_back(CH_U);
        if ($urandom_range(0, 1)) pending_bytes.push_back(CH_N);
        if ($urandom_range(0, 1)) pending_bytes.push_back(CH_E);
        pending_bytes.push_back(8'($urandom));
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (fail_count == 0 && frames_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
